// ----- rtl/core/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants for the sorted key table
// Entry layout, operation and status codes, widths and the conversion of a
// Q16.8 duration in seconds into a whole number of frames.
// ----------------------------------------------------------------------------
package skt_pkg;

   // Table geometry.
   localparam int CAPACITY   = 256;
   localparam int FRAME_RATE = 30;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   // Field widths of the beats on the request and response channels.
   localparam int OP_W       = 2;
   localparam int KEY_W      = 32;
   localparam int LENGTH_W   = 24;
   localparam int FRAC_BITS  = 8;
   localparam int STATUS_W   = 2;
   localparam int POSITION_W = 8;
   localparam int FRAME_W    = 21;
   localparam int COUNT_W    = 9;

   localparam int RATE_W     = $clog2(FRAME_RATE + 1);
   localparam int PROD_W     = LENGTH_W + RATE_W;
   localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};

   // Operation codes; any other code behaves as a lookup.
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DUP    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

   // One table entry as held by a cell.
   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [FRAME_W-1:0]      frames;
   } entry_type;

   // Control from the head unit to the ring of cells.
   typedef struct packed {
      logic      shift;
      entry_type tail;
   } chain_ctrl_type;

   // Frames = floor(length * FRAME_RATE / 256), saturated to the field width.
   function automatic logic [FRAME_W-1:0] to_frames(input logic [LENGTH_W-1:0] len);
      logic [PROD_W-1:0] prod;
      logic [PROD_W-1:0] whole;
      prod  = PROD_W'(len) * PROD_W'(FRAME_RATE);
      whole = prod >> FRAC_BITS;
      if (whole > PROD_W'(FRAME_MAX)) begin
         return FRAME_MAX;
      end
      return FRAME_W'(whole);
   endfunction

endpackage

// ----- rtl/core/skt_cell.sv -----
// ----------------------------------------------------------------------------
// skt_cell: one storage cell of the table ring
// Holds a single entry and, while the ring turns, takes the entry of its
// neighbor on the tail side.
// ----------------------------------------------------------------------------
module skt_cell (
   input  logic                clock,
   input  logic                shift,
   input  skt_pkg::entry_type  entry_nxt,
   output skt_pkg::entry_type  entry
);
   import skt_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // Hold, or take the neighbor's entry when the ring advances.
   always_comb begin
      entry_in = shift ? entry_nxt : entry_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ----- rtl/core/skt_ctrl.sv -----
// ----------------------------------------------------------------------------
// skt_ctrl: head unit of the table ring
// Takes a request beat, turns the ring once while it watches the entry at
// the head, finds the lower bound of the key on the way, edits the stream
// written back at the tail for insert and delete, and builds the response.
// ----------------------------------------------------------------------------
module skt_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [skt_pkg::OP_W-1:0]            req_operation,
   input  logic signed [skt_pkg::KEY_W-1:0]    req_key,
   input  logic [skt_pkg::LENGTH_W-1:0]        req_length_seconds,
   // Response channel.
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_success,
   output logic [skt_pkg::STATUS_W-1:0]        rsp_status,
   output logic [skt_pkg::POSITION_W-1:0]      rsp_position,
   output logic [skt_pkg::FRAME_W-1:0]         rsp_frame_length,
   output logic [skt_pkg::COUNT_W-1:0]         rsp_entry_count,
   // Ring side.
   input  skt_pkg::entry_type                  head,
   input  skt_pkg::entry_type                  look,
   output skt_pkg::chain_ctrl_type             chain
);
   import skt_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PASS = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]              state_ff,   state_in;
   logic [CNT_W-1:0]        occ_ff,     occ_in;
   logic [IDX_W-1:0]        idx_ff,     idx_in;
   logic                    found_ff,   found_in;
   logic                    hit_ff,     hit_in;
   logic                    ins_ff,     ins_in;
   logic                    del_ff,     del_in;
   logic [IDX_W-1:0]        pos_ff,     pos_in;
   logic [FRAME_W-1:0]      hit_frm_ff, hit_frm_in;
   logic [OP_W-1:0]         op_ff,      op_in;
   logic signed [KEY_W-1:0] key_ff,     key_in;
   logic [FRAME_W-1:0]      frm_ff,     frm_in;
   entry_type               buf_ff,     buf_in;

   logic                    rsp_valid_ff,   rsp_valid_in;
   logic                    rsp_success_ff, rsp_success_in;
   logic [STATUS_W-1:0]     rsp_status_ff,  rsp_status_in;
   logic [IDX_W-1:0]        rsp_pos_ff,     rsp_pos_in;
   logic [FRAME_W-1:0]      rsp_frm_ff,     rsp_frm_in;
   logic [CNT_W-1:0]        rsp_count_ff,   rsp_count_in;

   logic       accept;
   logic       in_range;
   logic       less;
   logic       bound;
   logic       match;
   logic       full;
   logic       last;
   logic       load;
   entry_type  fresh;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // Compare of the entry now at the head against the search key.
   assign in_range = ({1'b0, idx_ff} < (IDX_W + 1)'(occ_ff));
   assign less     = in_range && (head.key < key_ff);
   assign bound    = (state_ff == S_PASS) && !found_ff && !less;
   assign match    = bound && in_range && (head.key == key_ff);
   assign full     = (occ_ff == CNT_W'(CAPACITY));
   assign last     = (idx_ff == IDX_W'(CAPACITY - 1));
   assign load     = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   assign fresh.key    = key_ff;
   assign fresh.frames = frm_ff;

   // Sequencing and the edit of the stream written back at the tail.
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      found_in   = found_ff;
      hit_in     = hit_ff;
      ins_in     = ins_ff;
      del_in     = del_ff;
      pos_in     = pos_ff;
      hit_frm_in = hit_frm_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      frm_in     = frm_ff;
      buf_in     = buf_ff;
      chain.shift = 1'b0;
      chain.tail  = head;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_operation;
               key_in   = req_key;
               frm_in   = to_frames(req_length_seconds);
               idx_in   = '0;
               found_in = 1'b0;
               hit_in   = 1'b0;
               ins_in   = 1'b0;
               del_in   = 1'b0;
               pos_in   = '0;
               state_in = S_PASS;
            end
         end
         S_PASS: begin
            chain.shift = 1'b1;
            // The first entry not below the key is the lower bound.
            if (bound) begin
               found_in   = 1'b1;
               hit_in     = match;
               pos_in     = idx_ff;
               hit_frm_in = head.frames;
            end
            // Insert: place the new entry at the bound, then run one behind.
            if (bound && (op_ff == OP_INSERT) && !match && !full) begin
               chain.tail = fresh;
               buf_in     = head;
               ins_in     = 1'b1;
            end else if (ins_ff) begin
               chain.tail = buf_ff;
               buf_in     = head;
            end
            // Delete: from the match on, write the next entry instead.
            if ((bound && (op_ff == OP_DELETE) && match) || del_ff) begin
               chain.tail = look;
               del_in     = 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if (last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response beat and the new entry count.
   always_comb begin
      occ_in         = occ_ff;
      rsp_success_in = rsp_success_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_frm_in     = rsp_frm_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      if (load) begin
         rsp_valid_in   = 1'b1;
         rsp_success_in = 1'b0;
         rsp_status_in  = ST_ABSENT;
         rsp_pos_in     = '0;
         rsp_frm_in     = '0;
         case (op_ff)
            OP_INSERT: begin
               if (hit_ff) begin
                  rsp_status_in = ST_DUP;
                  rsp_pos_in    = pos_ff;
               end else if (full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  rsp_success_in = 1'b1;
                  rsp_status_in  = ST_OK;
                  rsp_pos_in     = pos_ff;
                  occ_in         = occ_ff + 1'b1;
               end
            end
            OP_DELETE: begin
               if (hit_ff) begin
                  rsp_success_in = 1'b1;
                  rsp_status_in  = ST_OK;
                  rsp_pos_in     = pos_ff;
                  occ_in         = occ_ff - 1'b1;
               end
            end
            default: begin
               if (hit_ff) begin
                  rsp_success_in = 1'b1;
                  rsp_status_in  = ST_OK;
                  rsp_pos_in     = pos_ff;
                  rsp_frm_in     = hit_frm_ff;
               end
            end
         endcase
         rsp_count_in = occ_in;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         found_ff     <= 1'b0;
         ins_ff       <= 1'b0;
         del_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         found_ff     <= found_in;
         ins_ff       <= ins_in;
         del_ff       <= del_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      hit_ff         <= hit_in;
      pos_ff         <= pos_in;
      hit_frm_ff     <= hit_frm_in;
      op_ff          <= op_in;
      key_ff         <= key_in;
      frm_ff         <= frm_in;
      buf_ff         <= buf_in;
      rsp_success_ff <= rsp_success_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_frm_ff     <= rsp_frm_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_success      = rsp_success_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_position     = POSITION_W'(rsp_pos_ff);
   assign rsp_frame_length = rsp_frm_ff;
   assign rsp_entry_count  = COUNT_W'(rsp_count_ff);

endmodule

// ----- rtl/core/sorted_key_table.sv -----
// ----------------------------------------------------------------------------
// sorted_key_table: table of entries kept in ascending signed key order
// Lookup, insert and delete by key over a ring of storage cells that turns
// once per request past a head unit.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   operation, key, length_seconds
//   rsp      out        rsp_valid/rsp_ready   success, status, position,
//                                             frame_length, entry_count
//
// Each request beat goes through the acceptance of the beat, one full turn of
// the ring with one entry per cycle past the head unit, and the load of the
// response register.
// Reset clears the entry count and the control state; the cells are not
// cleared, and only entries below the count are ever used.
// A new request is taken while the previous response still waits; a
// stalled response only holds the end of the next request's turn.
// ----------------------------------------------------------------------------
module sorted_key_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [skt_pkg::OP_W-1:0]            req_operation,
   input  logic signed [skt_pkg::KEY_W-1:0]    req_key,
   input  logic [skt_pkg::LENGTH_W-1:0]        req_length_seconds,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_success,
   output logic [skt_pkg::STATUS_W-1:0]        rsp_status,
   output logic [skt_pkg::POSITION_W-1:0]      rsp_position,
   output logic [skt_pkg::FRAME_W-1:0]         rsp_frame_length,
   output logic [skt_pkg::COUNT_W-1:0]         rsp_entry_count
);
   import skt_pkg::*;

   entry_type      entries [CAPACITY];
   chain_ctrl_type chain;

   // Head unit.
   skt_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_key            (req_key),
      .req_length_seconds (req_length_seconds),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_success        (rsp_success),
      .rsp_status         (rsp_status),
      .rsp_position       (rsp_position),
      .rsp_frame_length   (rsp_frame_length),
      .rsp_entry_count    (rsp_entry_count),
      .head               (entries[0]),
      .look               (entries[1]),
      .chain              (chain)
   );

   // Ring of cells: each takes its neighbor's entry, the last one the tail.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == CAPACITY - 1) begin : g_tail
         skt_cell u_cell (
            .clock     (clock),
            .shift     (chain.shift),
            .entry_nxt (chain.tail),
            .entry     (entries[i])
         );
      end else begin : g_body
         skt_cell u_cell (
            .clock     (clock),
            .shift     (chain.shift),
            .entry_nxt (entries[i + 1]),
            .entry     (entries[i])
         );
      end
   end

endmodule
